// ===== rtl/yuyv_to_bgr_flip_converter_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef YUYV_TO_BGR_FLIP_CONVERTER_MACROS_SVH
`define YUYV_TO_BGR_FLIP_CONVERTER_MACROS_SVH

// Checked on every rising edge outside reset.
`define YBF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define YBF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/ybf_pkg.sv =====
package ybf_pkg;

    localparam logic [12:0] MAX_WIDTH  = 13'd4096;
    localparam logic [12:0] MAX_HEIGHT = 13'd4096;

    localparam logic [12:0] RESET_WIDTH  = 13'd640;
    localparam logic [12:0] RESET_HEIGHT = 13'd480;

    // Configuration register indexes.
    localparam logic CFG_PIC_WIDTH  = 1'b0;
    localparam logic CFG_PIC_HEIGHT = 1'b1;

    // Chroma products are kept with 14 fractional bits.
    typedef logic signed [23:0] t_term;

    localparam t_term COEF_RV = 24'sd22970;
    localparam t_term COEF_GU = 24'sd5638;
    localparam t_term COEF_GV = 24'sd11700;
    localparam t_term COEF_BU = 24'sd29032;

    typedef struct packed {
        t_term bu;
        t_term g;
        t_term rv;
    } t_chroma_terms;

    typedef struct packed {
        logic [12:0] pic_width;
        logic [12:0] pic_height;
    } t_frame_cfg;

endpackage

// ===== rtl/ybf_lane.sv =====
module ybf_lane (
    input  logic                   [7:0] i_luma,
    input  ybf_pkg::t_chroma_terms       i_terms,
    output logic                   [7:0] o_blue,
    output logic                   [7:0] o_green,
    output logic                   [7:0] o_red
);

    logic signed [24:0] base;
    logic signed [24:0] sum_b;
    logic signed [24:0] sum_g;
    logic signed [24:0] sum_r;

    // A negative sum truncates to zero or below, so the sign alone clamps it low.
    function automatic logic [7:0] clamp_sum(input logic signed [24:0] s);
        logic [7:0] v;
        if (s[24]) begin
            v = 8'd0;
        end else if (|s[23:22]) begin
            v = 8'd255;
        end else begin
            v = s[21:14];
        end
        return v;
    endfunction

    assign base  = signed'({3'b000, i_luma, 14'd0});
    assign sum_b = base + 25'(i_terms.bu);
    assign sum_g = base - 25'(i_terms.g);
    assign sum_r = base + 25'(i_terms.rv);

    assign o_blue  = clamp_sum(sum_b);
    assign o_green = clamp_sum(sum_g);
    assign o_red   = clamp_sum(sum_r);

endmodule

// ===== rtl/ybf_addr.sv =====
module ybf_addr (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  ybf_pkg::t_frame_cfg i_cfg,
    output logic         [22:0] o_dest_pair_index,
    output logic                o_last_of_frame
);

    logic [10:0] r_col;
    logic [11:0] r_row;
    logic [11:0] r_flip_row;
    logic [11:0] r_pairs;
    logic [10:0] r_col_eff;
    logic        r_last;

    logic [12:0] width_lim;
    logic [12:0] rows;
    logic [11:0] pairs;
    logic        last_col;
    logic        last_row;
    logic [11:0] col_eff;
    logic [12:0] row_eff;
    logic [12:0] flip_row;
    logic [23:0] prod;

    always_comb begin
        width_lim = (i_cfg.pic_width > ybf_pkg::MAX_WIDTH) ? ybf_pkg::MAX_WIDTH
                                                           : i_cfg.pic_width;
        rows      = (i_cfg.pic_height > ybf_pkg::MAX_HEIGHT) ? ybf_pkg::MAX_HEIGHT
                                                             : i_cfg.pic_height;
        pairs     = width_lim[12:1];
        if (pairs == 12'd0) begin
            pairs = 12'd1;
        end
        if (rows == 13'd0) begin
            rows = 13'd1;
        end
        last_col = (12'(r_col) + 12'd1) >= pairs;
        last_row = (13'(r_row) + 13'd1) >= rows;
        // A counter left out of range by a register write acts as the last one.
        col_eff  = last_col ? (pairs - 12'd1) : 12'(r_col);
        row_eff  = last_row ? (rows - 13'd1) : 13'(r_row);
        flip_row = rows - 13'd1 - row_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_load) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? 12'd0 : (r_row + 12'd1);
            end else begin
                r_col <= r_col + 11'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_flip_row <= flip_row[11:0];
            r_pairs    <= pairs;
            r_col_eff  <= col_eff[10:0];
            r_last     <= last_col && last_row;
        end
    end

    assign prod              = 24'(r_flip_row) * 24'(r_pairs);
    assign o_dest_pair_index = prod[22:0] + 23'(r_col_eff);
    assign o_last_of_frame   = r_last;

endmodule

// ===== rtl/yuyv_to_bgr_flip_converter.sv =====
// YUYV macropixel to two BGR pixels with a vertically flipped pair index.
// The chroma products are registered first, then the sums in the output register.
// Throughput: one macropixel per cycle; the two-stage pipeline stalls only when
// the output register is held by the consumer.
// Reset (synchronous, active low) empties the pipeline, clears the column and
// row counters and loads width 640 and height 480.
module yuyv_to_bgr_flip_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic  [7:0] i_luma0,
    input  logic  [7:0] i_chroma_blue,
    input  logic  [7:0] i_luma1,
    input  logic  [7:0] i_chroma_red,
    output logic        o_valid,
    input  logic        i_ready,
    output logic  [7:0] o_blue0,
    output logic  [7:0] o_green0,
    output logic  [7:0] o_red0,
    output logic  [7:0] o_blue1,
    output logic  [7:0] o_green1,
    output logic  [7:0] o_red1,
    output logic [22:0] o_dest_pair_index,
    output logic        o_last_of_frame
);

    ybf_pkg::t_frame_cfg    r_cfg;
    logic                   r_v1;
    logic                   r_v2;
    logic             [7:0] r_y0;
    logic             [7:0] r_y1;
    ybf_pkg::t_chroma_terms r_terms;
    ybf_pkg::t_chroma_terms n_terms;

    logic        [7:0] r_blue0, r_green0, r_red0;
    logic        [7:0] r_blue1, r_green1, r_red1;
    logic       [22:0] r_dest;
    logic              r_last;

    logic signed [7:0] cu;
    logic signed [7:0] cv;
    logic              adv2;
    logic              load1;
    logic        [7:0] l0_b, l0_g, l0_r;
    logic        [7:0] l1_b, l1_g, l1_r;
    logic       [22:0] dest_index;
    logic              last_pair;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pic_width  <= ybf_pkg::RESET_WIDTH;
            r_cfg.pic_height <= ybf_pkg::RESET_HEIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ybf_pkg::CFG_PIC_WIDTH:  r_cfg.pic_width  <= i_cfg_data;
                ybf_pkg::CFG_PIC_HEIGHT: r_cfg.pic_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The output register loads when empty or when its result is taken.
    assign adv2    = !r_v2 || i_ready;
    assign o_ready = !r_v1 || adv2;
    assign load1   = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Offset-128 bytes become two's complement by inverting the top bit.
    assign cu = {~i_chroma_blue[7], i_chroma_blue[6:0]};
    assign cv = {~i_chroma_red[7], i_chroma_red[6:0]};

    always_comb begin
        n_terms.bu = ybf_pkg::t_term'(cu) * ybf_pkg::COEF_BU;
        n_terms.g  = ybf_pkg::t_term'(cu) * ybf_pkg::COEF_GU
                   + ybf_pkg::t_term'(cv) * ybf_pkg::COEF_GV;
        n_terms.rv = ybf_pkg::t_term'(cv) * ybf_pkg::COEF_RV;
    end

    always_ff @(posedge i_clk) begin
        if (load1) begin
            r_y0    <= i_luma0;
            r_y1    <= i_luma1;
            r_terms <= n_terms;
        end
    end

    ybf_lane u_lane0 (
        .i_luma  (r_y0),
        .i_terms (r_terms),
        .o_blue  (l0_b),
        .o_green (l0_g),
        .o_red   (l0_r)
    );

    ybf_lane u_lane1 (
        .i_luma  (r_y1),
        .i_terms (r_terms),
        .o_blue  (l1_b),
        .o_green (l1_g),
        .o_red   (l1_r)
    );

    ybf_addr u_addr (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (load1),
        .i_cfg             (r_cfg),
        .o_dest_pair_index (dest_index),
        .o_last_of_frame   (last_pair)
    );

    // Merge both lanes and the address into the output register.
    always_ff @(posedge i_clk) begin
        if (adv2 && r_v1) begin
            r_blue0  <= l0_b;
            r_green0 <= l0_g;
            r_red0   <= l0_r;
            r_blue1  <= l1_b;
            r_green1 <= l1_g;
            r_red1   <= l1_r;
            r_dest   <= dest_index;
            r_last   <= last_pair;
        end
    end

    assign o_valid           = r_v2;
    assign o_blue0           = r_blue0;
    assign o_green0          = r_green0;
    assign o_red0            = r_red0;
    assign o_blue1           = r_blue1;
    assign o_green1          = r_green1;
    assign o_red1            = r_red1;
    assign o_dest_pair_index = r_dest;
    assign o_last_of_frame   = r_last;

endmodule

// ===== rtl/ybf_checker.sv =====
`include "yuyv_to_bgr_flip_converter_macros.svh"

module ybf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [22:0] o_dest_pair_index,
    input logic        o_last_of_frame
);

    // A result that is not taken stays offered.
    `YBF_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid, "result dropped while stalled")

    // The input side only stalls when the output register is full.
    `YBF_ASSERT(a_stall_full, !o_ready |-> o_valid, "input stalled with empty output")

    // The last pair of a frame lands in the first destination row.
    `YBF_ASSERT(a_last_row0, o_valid && o_last_of_frame |-> o_dest_pair_index < 23'd2048,
        "frame end outside first destination row")

    // Reset empties the pipeline.
    `YBF_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind yuyv_to_bgr_flip_converter ybf_checker u_ybf_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int FRAC_BITS = 14;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 64;

    typedef struct packed {
        logic [7:0] luma0;
        logic [7:0] chroma_blue;
        logic [7:0] luma1;
        logic [7:0] chroma_red;
    } t_macropixel;

    typedef struct packed {
        logic [7:0]  blue0;
        logic [7:0]  green0;
        logic [7:0]  red0;
        logic [7:0]  blue1;
        logic [7:0]  green1;
        logic [7:0]  red1;
        logic [22:0] dest_pair_index;
        logic        last_of_frame;
    } t_pair_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = ybf_pkg::CFG_PIC_WIDTH;
    logic [12:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_luma0 = '0;
    logic [7:0]  i_chroma_blue = '0;
    logic [7:0]  i_luma1 = '0;
    logic [7:0]  i_chroma_red = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_blue0;
    logic [7:0]  o_green0;
    logic [7:0]  o_red0;
    logic [7:0]  o_blue1;
    logic [7:0]  o_green1;
    logic [7:0]  o_red1;
    logic [22:0] o_dest_pair_index;
    logic        o_last_of_frame;

    yuyv_to_bgr_flip_converter dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_luma0           (i_luma0),
        .i_chroma_blue     (i_chroma_blue),
        .i_luma1           (i_luma1),
        .i_chroma_red      (i_chroma_red),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_blue0           (o_blue0),
        .o_green0          (o_green0),
        .o_red0            (o_red0),
        .o_blue1           (o_blue1),
        .o_green1          (o_green1),
        .o_red1            (o_red1),
        .o_dest_pair_index (o_dest_pair_index),
        .o_last_of_frame   (o_last_of_frame)
    );

    always #2 i_clk = ~i_clk;

    t_macropixel  pixel_queue[$];
    t_pair_result expected_pairs[$];
    t_macropixel  next_pixel;

    int  snd_idle_pct = 0;
    int  rcv_idle_pct = 0;
    bit  hold_armed = 1'b0;
    int  hold_count = 0;
    bit  in_taken = 1'b0;
    bit  cfg_taken = 1'b0;
    int  error_count = 0;
    int  quiet_cycles = 0;

    // Local copy of the frame geometry and the raster position.
    logic [12:0] frame_width = ybf_pkg::RESET_WIDTH;
    logic [12:0] frame_height = ybf_pkg::RESET_HEIGHT;
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;

    function automatic logic [7:0] clamp_byte(input int sum);
        int v;
        v = sum / (1 << FRAC_BITS);
        if (v < 0) begin
            return 8'd0;
        end
        if (v > 255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

    // Converts one macropixel and advances the raster position.
    function automatic t_pair_result convert_macropixel(input t_macropixel mp);
        t_pair_result res;
        int unsigned  lim_w, rows, pairs, col, row, slot;
        logic         last_col, last_row;
        int           y0, y1, cu, cv;
        y0 = int'(mp.luma0) << FRAC_BITS;
        y1 = int'(mp.luma1) << FRAC_BITS;
        cu = int'(mp.chroma_blue) - 128;
        cv = int'(mp.chroma_red) - 128;
        res.blue0  = clamp_byte(y0 + int'(ybf_pkg::COEF_BU) * cu);
        res.green0 = clamp_byte(y0 - int'(ybf_pkg::COEF_GU) * cu
                                   - int'(ybf_pkg::COEF_GV) * cv);
        res.red0   = clamp_byte(y0 + int'(ybf_pkg::COEF_RV) * cv);
        res.blue1  = clamp_byte(y1 + int'(ybf_pkg::COEF_BU) * cu);
        res.green1 = clamp_byte(y1 - int'(ybf_pkg::COEF_GU) * cu
                                   - int'(ybf_pkg::COEF_GV) * cv);
        res.red1   = clamp_byte(y1 + int'(ybf_pkg::COEF_RV) * cv);

        lim_w = (frame_width < ybf_pkg::MAX_WIDTH) ? frame_width : ybf_pkg::MAX_WIDTH;
        rows  = (frame_height < ybf_pkg::MAX_HEIGHT) ? frame_height : ybf_pkg::MAX_HEIGHT;
        pairs = lim_w >> 1;
        if (pairs == 0) begin
            pairs = 1;
        end
        if (rows == 0) begin
            rows = 1;
        end
        // A position left beyond a shrunken frame counts as the last one.
        last_col = (col_pos + 1 >= pairs);
        last_row = (row_pos + 1 >= rows);
        col = last_col ? pairs - 1 : col_pos;
        row = last_row ? rows - 1 : row_pos;
        slot = (rows - 1 - row) * pairs + col;
        res.dest_pair_index = slot[22:0];
        res.last_of_frame = last_col && last_row;

        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : ((row_pos + 1) & 12'hFFF);
        end else begin
            col_pos = (col_pos + 1) & 11'h7FF;
        end
        return res;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %0d actual %0d",
                     $time, name, want, got);
        end
    endfunction

    // Sender: a new macropixel is offered only once the previous one transferred.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                next_pixel = pixel_queue.pop_front();
                i_valid       <= 1'b1;
                i_luma0       <= next_pixel.luma0;
                i_chroma_blue <= next_pixel.chroma_blue;
                i_luma1       <= next_pixel.luma1;
                i_chroma_red  <= next_pixel.chroma_red;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver, with one long hold-off once armed so the pipeline backs up.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_armed && hold_count < HOLD_CYCLES) begin
            i_ready <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            i_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_pair_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ybf_pkg::CFG_PIC_WIDTH:  frame_width = i_cfg_data;
                    ybf_pkg::CFG_PIC_HEIGHT: frame_height = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                expected_pairs.insert(expected_pairs.size(), convert_macropixel(
                    {i_luma0, i_chroma_blue, i_luma1, i_chroma_red}));
            end
            if (o_valid && i_ready) begin
                if (expected_pairs.size() == 0) begin
                    error_count++;
                    $display("%0t ns: result transfer with no pending expectation", $time);
                end else begin
                    want = expected_pairs.pop_front();
                    check_field("blue0", want.blue0, o_blue0);
                    check_field("green0", want.green0, o_green0);
                    check_field("red0", want.red0, o_red0);
                    check_field("blue1", want.blue1, o_blue1);
                    check_field("green1", want.green1, o_green1);
                    check_field("red1", want.red1, o_red1);
                    check_field("dest_pair_index", want.dest_pair_index,
                                o_dest_pair_index);
                    check_field("last_of_frame", want.last_of_frame, o_last_of_frame);
                end
            end
            in_taken  <= i_valid && o_ready;
            cfg_taken <= i_cfg_valid && o_cfg_ready;
        end else begin
            in_taken  <= 1'b0;
            cfg_taken <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic add_pixel(input logic [7:0] y0, input logic [7:0] u,
                             input logic [7:0] y1, input logic [7:0] v);
        pixel_queue.insert(pixel_queue.size(), {y0, u, y1, v});
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd128;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Waits until every macropixel has transferred and every result has come back.
    task automatic wait_drained();
        @(posedge i_clk);
        while (pixel_queue.size() != 0 || i_valid || expected_pairs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [12:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        while (!cfg_taken) begin
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(input logic [12:0] w, input logic [12:0] h);
        wait_drained();
        write_reg(ybf_pkg::CFG_PIC_WIDTH, w);
        write_reg(ybf_pkg::CFG_PIC_HEIGHT, h);
        @(posedge i_clk);
    endtask

    initial begin
        logic [12:0] w, h;
        int n;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        snd_idle_pct = 30;
        rcv_idle_pct = 53;

        // Reset geometry, color extremes and clamping at both ends.
        @(posedge i_clk);
        add_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        add_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        add_pixel(8'd255, 8'd0, 8'd0, 8'd255);
        add_pixel(8'd0, 8'd255, 8'd255, 8'd0);
        add_pixel(8'd128, 8'd128, 8'd128, 8'd128);
        add_pixel(8'd0, 8'd129, 8'd1, 8'd127);

        // The column is now past the new row length, then frames wrap.
        set_frame(13'd4, 13'd3);
        for (int i = 0; i < 8; i++) begin
            add_pixel(8'(i * 37), 8'(255 - i * 30), 8'(i * 16), 8'(i * 29));
        end

        // Zero height counts as one row: every pair ends a frame.
        set_frame(13'd2, 13'd0);
        add_pixel(8'd10, 8'd240, 8'd250, 8'd20);
        add_pixel(8'd200, 8'd60, 8'd30, 8'd220);
        add_pixel(8'd77, 8'd128, 8'd177, 8'd128);

        // Oversized registers are limited to the largest frame.
        set_frame(13'd8191, 13'd8191);
        add_pixel(8'd255, 8'd255, 8'd0, 8'd0);
        add_pixel(8'd0, 8'd0, 8'd255, 8'd255);
        add_pixel(8'd90, 8'd170, 8'd45, 8'd85);

        // Width of one pixel still yields one pair per row.
        set_frame(13'd1, 13'd4096);
        add_pixel(8'd1, 8'd2, 8'd3, 8'd4);
        add_pixel(8'd254, 8'd253, 8'd252, 8'd251);

        for (int sec = 0; sec < 3; sec++) begin
            for (int ph = 0; ph < 5; ph++) begin
                case ($urandom_range(9))
                    7: w = 13'($urandom_range(8191));
                    8: w = 13'($urandom_range(4090, 4100));
                    9: w = 13'($urandom_range(1));
                    default: w = 13'($urandom_range(2, 20));
                endcase
                case ($urandom_range(9))
                    8: h = 13'($urandom_range(8191));
                    9: h = 13'd0;
                    default: h = 13'($urandom_range(1, 10));
                endcase
                set_frame(w, h);
                if (ph == 0) begin
                    snd_idle_pct = (sec == 0) ? 30 : (sec == 1) ? 53 : 0;
                    rcv_idle_pct = (sec == 0) ? 53 : (sec == 1) ? 30 : 0;
                    hold_armed = (sec == 2);
                end
                n = $urandom_range(90, 115);
                for (int i = 0; i < n; i++) begin
                    add_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
                end
            end
        end

        wait_drained();
        repeat (6) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
